>>> design/prot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prot_pkg;

  localparam int NODE_COUNT_DEF = 256;
  localparam int LIST_LIMIT_DEF = 9;

  localparam int KIND_W   = 3;
  localparam int NODE_W   = 8;
  localparam int OWNER_W  = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  localparam logic [KIND_W-1:0] KIND_RESERVE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REL_ALL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LIST    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SET     = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LISTED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LIST_END = 2'd3;

  typedef struct packed {
    logic clear;   // clearing pass, one entry
    logic accept;  // latch request
    logic fetch;   // read tables at the addressed node
    logic eval;    // decide and write addressed entry
    logic twin;    // write twin entry
    logic scan;    // scan step
    logic gsel;    // move to second forced node
    logic resp;    // emit pending single result
    logic lend;    // emit list end result
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic twin_go;
    logic scan_done;
    logic out_free;
    logic is_list;
    logic ov;
    logic gsel;
  } sts_t;

endpackage

`default_nettype wire

>>> design/paired_resource_owner_table_unit.sv
// Paired resource owner table.
// Input channel in_*: one request item per handshake (tvalid & tready). The
// kind travels in in_tuser; node, owner, other node and other-valid in tdata.
// Output channel out_*: one or more result items per request, tlast set on
// the final one; status in out_tuser, holder/listed node/count in tdata.
// Requests are handled one at a time by a sequencer over two simple
// dual-port tables (one write and one registered read per cycle).
// Reserve, release, read, set partner and unknown kinds read the addressed
// entry, then decide and answer. Release all scans the table, clears the
// owner's entries and, with other-valid set, grants the node and the other
// node to the owner. List scans the table and stops once the list limit
// is hit. Scans read one entry per cycle while no listed node waits; the
// next request is taken only once the sequencer is idle again.
// Reset: a clearing pass zeroes every entry of both tables; in_tready
// stays low meanwhile.
// Stall: results sit in an output register; a list scan pauses while a
// listed node waits, and the next request is taken only after the final
// result of the current one is registered.
`timescale 1ns / 1ps
`default_nettype none

module paired_resource_owner_table_unit #(
  parameter int NODE_COUNT = prot_pkg::NODE_COUNT_DEF,
  parameter int LIST_LIMIT = prot_pkg::LIST_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // node[7:0], owner_id[15:8], other_node[23:16],
                                       // other_valid[24]
  input  wire logic [2:0]  in_tuser,   // kind[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // holder[7:0], listed_node[15:8], listed_count[19:16]
  output logic [1:0]       out_tuser,  // status[1:0]
  output logic             out_tlast
);
  import prot_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [STATUS_W-1:0] status;
  logic [OWNER_W-1:0]  holder;
  logic [NODE_W-1:0]   lnode;
  logic [COUNT_W-1:0]  count;

  prot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prot_dp #(
    .NODE_COUNT (NODE_COUNT),
    .LIST_LIMIT (LIST_LIMIT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_tuser),
    .in_node    (in_tdata[7:0]),
    .in_owner   (in_tdata[15:8]),
    .in_other   (in_tdata[23:16]),
    .in_ov      (in_tdata[24]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_status (status),
    .out_holder (holder),
    .out_lnode  (lnode),
    .out_count  (count),
    .out_last   (out_tlast)
  );

  assign out_tuser = status;
  assign out_tdata = {4'd0, count, lnode, holder};

endmodule

`default_nettype wire

>>> design/prot_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module prot_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  input  wire logic [prot_pkg::KIND_W-1:0]  in_kind,
  output logic                              in_tready,
  input  wire prot_pkg::sts_t               sts,
  output prot_pkg::cmd_t                    cmd
);
  import prot_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_FETCH  = 4'd2;
  localparam logic [3:0] S_EVAL   = 4'd3;
  localparam logic [3:0] S_TWIN   = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_GFETCH = 4'd6;
  localparam logic [3:0] S_GEVAL  = 4'd7;
  localparam logic [3:0] S_GTWIN  = 4'd8;
  localparam logic [3:0] S_RESP   = 4'd9;
  localparam logic [3:0] S_LEND   = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (in_kind inside {KIND_REL_ALL, KIND_LIST}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_nxt = sts.twin_go ? S_TWIN : S_RESP;
      end
      S_TWIN: begin
        cmd.twin = 1'b1;
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          if (sts.is_list) state_nxt = S_LEND;
          else if (sts.ov) state_nxt = S_GFETCH;
          else state_nxt = S_RESP;
        end
      end
      S_GFETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_GEVAL;
      end
      S_GEVAL: begin
        cmd.eval = 1'b1;
        if (sts.twin_go) begin
          state_nxt = S_GTWIN;
        end else if (sts.gsel) begin
          state_nxt = S_RESP;
        end else begin
          cmd.gsel = 1'b1;
          state_nxt = S_GFETCH;
        end
      end
      S_GTWIN: begin
        cmd.twin = 1'b1;
        if (sts.gsel) begin
          state_nxt = S_RESP;
        end else begin
          cmd.gsel = 1'b1;
          state_nxt = S_GFETCH;
        end
      end
      S_RESP: begin
        cmd.resp = 1'b1;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_LEND: begin
        cmd.lend = 1'b1;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/prot_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module prot_dp #(
  parameter int NODE_COUNT = prot_pkg::NODE_COUNT_DEF,
  parameter int LIST_LIMIT = prot_pkg::LIST_LIMIT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire prot_pkg::cmd_t                 cmd,
  output prot_pkg::sts_t                      sts,
  input  wire logic [prot_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [prot_pkg::NODE_W-1:0]    in_node,
  input  wire logic [prot_pkg::OWNER_W-1:0]   in_owner,
  input  wire logic [prot_pkg::NODE_W-1:0]    in_other,
  input  wire logic                           in_ov,
  input  wire logic                           out_tready,
  output logic                                out_tvalid,
  output logic [prot_pkg::STATUS_W-1:0]       out_status,
  output logic [prot_pkg::OWNER_W-1:0]        out_holder,
  output logic [prot_pkg::NODE_W-1:0]         out_lnode,
  output logic [prot_pkg::COUNT_W-1:0]        out_count,
  output logic                                out_last
);
  import prot_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);
  localparam int CW = AW + 1;

  logic [OWNER_W-1:0]  owner_mem   [NODE_COUNT];
  logic [NODE_W:0]     partner_mem [NODE_COUNT];

  logic [KIND_W-1:0]   req_kind_r;
  logic [NODE_W-1:0]   req_node_r, req_other_r;
  logic [OWNER_W-1:0]  req_owner_r;
  logic                req_ov_r;
  logic                gsel_r;
  logic [CW-1:0]       cnt_r;
  logic                dv_r;
  logic [COUNT_W-1:0]  k_r;
  logic [AW-1:0]       daddr_r;
  logic [OWNER_W-1:0]  own_q_r;
  logic [NODE_W:0]     par_q_r;
  logic [STATUS_W-1:0] pend_status_r;
  logic [OWNER_W-1:0]  pend_holder_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [OWNER_W-1:0]  out_holder_r;
  logic [NODE_W-1:0]   out_lnode_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_last_r;

  logic [NODE_W-1:0]   gnode, twin;
  logic                g_in, twin_in, pv, write_ok, out_free;
  logic [OWNER_W-1:0]  own_val;
  logic                cnt_end, is_list, k_full, hit, list_emit, adv, relall_clr;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                owr_en, pwr_en;
  logic [AW-1:0]       owr_addr, pwr_addr;
  logic [OWNER_W-1:0]  owr_data;
  logic [NODE_W:0]     pwr_data;
  logic                resp_ld, list_ld, lend_ld;

  assign gnode   = gsel_r ? req_other_r : req_node_r;
  assign g_in    = {1'b0, gnode} < (NODE_W + 1)'(NODE_COUNT);
  assign twin    = par_q_r[NODE_W-1:0];
  assign pv      = par_q_r[NODE_W];
  assign twin_in = {1'b0, twin} < (NODE_W + 1)'(NODE_COUNT);
  assign own_val = (req_kind_r == KIND_RELEASE) ? '0 : req_owner_r;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    case (req_kind_r)
      KIND_RESERVE: write_ok = g_in && (own_q_r == '0);
      KIND_RELEASE: write_ok = g_in && (own_q_r == req_owner_r);
      KIND_REL_ALL: write_ok = g_in;
      default:      write_ok = 1'b0;
    endcase
  end

  // scan pipeline: read issued at cnt_r, compared in the cycle after at daddr_r
  assign cnt_end    = (cnt_r == CW'(NODE_COUNT));
  assign is_list    = (req_kind_r == KIND_LIST);
  assign k_full     = (k_r == COUNT_W'(LIST_LIMIT));
  assign hit        = dv_r && (own_q_r == req_owner_r) && (!pv || twin > NODE_W'(daddr_r));
  assign list_emit  = cmd.scan && is_list && !k_full && hit;
  assign adv        = cmd.scan && !(list_emit && !out_free);
  assign relall_clr = cmd.scan && !is_list && dv_r && (own_q_r == req_owner_r);

  assign rd_en   = cmd.fetch || (adv && !cnt_end);
  assign rd_addr = cmd.fetch ? gnode[AW-1:0] : cnt_r[AW-1:0];

  always_comb begin
    owr_en   = 1'b0;
    owr_addr = cnt_r[AW-1:0];
    owr_data = '0;
    if (cmd.clear) begin
      owr_en = 1'b1;
    end else if (cmd.eval && write_ok) begin
      owr_en   = 1'b1;
      owr_addr = gnode[AW-1:0];
      owr_data = own_val;
    end else if (cmd.twin) begin
      owr_en   = 1'b1;
      owr_addr = twin[AW-1:0];
      owr_data = own_val;
    end else if (relall_clr) begin
      owr_en   = 1'b1;
      owr_addr = daddr_r;
    end
  end

  always_comb begin
    pwr_en   = 1'b0;
    pwr_addr = cnt_r[AW-1:0];
    pwr_data = '0;
    if (cmd.clear) begin
      pwr_en = 1'b1;
    end else if (cmd.eval && req_kind_r == KIND_SET && g_in) begin
      pwr_en   = 1'b1;
      pwr_addr = gnode[AW-1:0];
      pwr_data = {req_ov_r, req_other_r};
    end
  end

  always_ff @(posedge clk) begin
    if (owr_en) owner_mem[owr_addr] <= owr_data;
    if (pwr_en) partner_mem[pwr_addr] <= pwr_data;
    if (rd_en) begin
      own_q_r <= owner_mem[rd_addr];
      par_q_r <= partner_mem[rd_addr];
      daddr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_kind_r  <= in_kind;
      req_node_r  <= in_node;
      req_owner_r <= in_owner;
      req_other_r <= in_other;
      req_ov_r    <= in_ov;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      dv_r   <= 1'b0;
      k_r    <= '0;
      gsel_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        cnt_r  <= '0;
        dv_r   <= 1'b0;
        k_r    <= '0;
        gsel_r <= 1'b0;
      end else begin
        if (cmd.clear || (adv && !cnt_end)) cnt_r <= cnt_r + CW'(1);
        if (adv) dv_r <= !cnt_end;
        if (list_ld) k_r <= k_r + COUNT_W'(1);
        if (cmd.gsel) gsel_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_status_r <= ST_DONE;
      pend_holder_r <= '0;
    end else if (cmd.eval) begin
      case (req_kind_r)
        KIND_RESERVE: begin
          if (!g_in) begin
            pend_status_r <= ST_REFUSED;
            pend_holder_r <= '0;
          end else if (own_q_r == '0 || own_q_r == req_owner_r) begin
            pend_status_r <= ST_DONE;
            pend_holder_r <= '0;
          end else begin
            pend_status_r <= ST_REFUSED;
            pend_holder_r <= own_q_r;
          end
        end
        KIND_READ: begin
          pend_status_r <= g_in ? ST_DONE : ST_REFUSED;
          pend_holder_r <= g_in ? own_q_r : '0;
        end
        KIND_RELEASE, KIND_REL_ALL, KIND_SET: begin
          pend_status_r <= ST_DONE;
          pend_holder_r <= '0;
        end
        default: begin
          pend_status_r <= ST_REFUSED;
          pend_holder_r <= '0;
        end
      endcase
    end
  end

  assign resp_ld = cmd.resp && out_free;
  assign list_ld = list_emit && out_free;
  assign lend_ld = cmd.lend && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_ld || list_ld || lend_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_ld) begin
      out_status_r <= pend_status_r;
      out_holder_r <= pend_holder_r;
      out_lnode_r  <= '0;
      out_count_r  <= '0;
      out_last_r   <= 1'b1;
    end else if (list_ld) begin
      out_status_r <= ST_LISTED;
      out_holder_r <= '0;
      out_lnode_r  <= NODE_W'(daddr_r);
      out_count_r  <= '0;
      out_last_r   <= 1'b0;
    end else if (lend_ld) begin
      out_status_r <= ST_LIST_END;
      out_holder_r <= '0;
      out_lnode_r  <= '0;
      out_count_r  <= k_r;
      out_last_r   <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_holder = out_holder_r;
  assign out_lnode  = out_lnode_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

  assign sts.clear_last = (cnt_r[AW-1:0] == AW'(NODE_COUNT - 1));
  assign sts.twin_go    = write_ok && pv && twin_in;
  assign sts.scan_done  = (!dv_r && cnt_end) || (is_list && k_full);
  assign sts.out_free   = out_free;
  assign sts.is_list    = is_list;
  assign sts.ov         = req_ov_r;
  assign sts.gsel       = gsel_r;

endmodule

`default_nettype wire
